// File: rtl/kqt_pkg.sv
// Shared types and codes for the keyed quantity table.
`default_nettype none

package kqt_pkg;

    localparam int FIELD_KEY_BITS = 16;
    localparam int FIELD_QTY_BITS = 32;
    localparam int POS_BITS       = 7;

    localparam logic [1:0] MODE_LIST  = 2'd0;
    localparam logic [1:0] MODE_STORE = 2'd1;
    localparam logic [1:0] MODE_OFF   = 2'd2;
    localparam logic [1:0] MODE_NONE  = 2'd3;

    localparam logic [2:0] ST_LISTED   = 3'd0;
    localparam logic [2:0] ST_EMPTY    = 3'd1;
    localparam logic [2:0] ST_NEW      = 3'd2;
    localparam logic [2:0] ST_ADDED    = 3'd3;
    localparam logic [2:0] ST_FULL     = 3'd4;
    localparam logic [2:0] ST_REDUCED  = 3'd5;
    localparam logic [2:0] ST_REMOVED  = 3'd6;
    localparam logic [2:0] ST_NOTFOUND = 3'd7;

    typedef struct packed {
        logic [1:0]                mode;
        logic [FIELD_KEY_BITS-1:0] goods_type;
        logic [FIELD_QTY_BITS-1:0] quantity;
    } req_t;

    typedef struct packed {
        logic [2:0]                status;
        logic [POS_BITS-1:0]       position;
        logic [FIELD_KEY_BITS-1:0] entry_type;
        logic [FIELD_QTY_BITS-1:0] entry_quantity;
        logic                      last;
    } rsp_t;

    // Sequencer status seen by the top level.
    typedef struct packed {
        logic                busy;
        logic [POS_BITS-1:0] count;
    } kqt_stat_t;

endpackage

`default_nettype wire

// File: rtl/keyed_quantity_table.sv
// Top level of the keyed quantity table: cell ring, sequencer and checks.
//
//   channel | direction | payload | handshake
//   --------+-----------+---------+----------------------------------
//   request | in        | req     | req_valid / req_stall
//   result  | out       | rsp     | rsp_valid / rsp_stall
//
// Every list, store or offstore request turns the ring of DEPTH cells once,
// one cell per cycle unless a result waits on rsp_stall, from the cycle
// after the accepting edge. req_stall stays high for the whole turn, so no
// new request is taken until it ends. Mode 3 is dropped at the accepting
// edge and stalls nothing. Store and offstore give a single result, made
// at the last step; list gives one per valid entry, or one empty result.
// Reset clears the entry count and the handshake state; the cell contents
// are not reset.
`default_nettype none

module keyed_quantity_table import kqt_pkg::*; #(
    parameter int DEPTH    = 16,
    parameter int KEY_BITS = 16,
    parameter int QTY_BITS = 32
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic req_valid,
    output logic      req_stall,
    input  wire req_t req,
    output logic      rsp_valid,
    input  wire logic rsp_stall,
    output rsp_t      rsp
);

    localparam int KW = (KEY_BITS < FIELD_KEY_BITS) ? KEY_BITS : FIELD_KEY_BITS;
    localparam int QW = QTY_BITS;

    logic [KW-1:0] key_q [DEPTH];
    logic [QW-1:0] amt_q [DEPTH];
    logic [KW-1:0] tail_key, next_key;
    logic [QW-1:0] tail_amt, next_amt;
    logic          rotate;
    kqt_stat_t     stat;

    kqt_ctrl #(
        .DEPTH (DEPTH),
        .KW    (KW),
        .QW    (QW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req       (req),
        .rsp_stall (rsp_stall),
        .rsp_valid (rsp_valid),
        .rsp       (rsp),
        .stat      (stat),
        .head_key  (key_q[0]),
        .head_amt  (amt_q[0]),
        .next_key  (next_key),
        .next_amt  (next_amt),
        .rotate    (rotate),
        .tail_key  (tail_key),
        .tail_amt  (tail_amt)
    );

    generate
        if (DEPTH > 1)
        begin : g_next
            assign next_key = key_q[1];
            assign next_amt = amt_q[1];
        end
        else
        begin : g_next_one
            assign next_key = key_q[0];
            assign next_amt = amt_q[0];
        end
    endgenerate

    genvar i;
    generate
        for (i = 0; i < DEPTH; i++)
        begin : g_cell
            logic [KW-1:0] key_in;
            logic [QW-1:0] amt_in;
            if (i == DEPTH - 1)
            begin : g_tail
                assign key_in = tail_key;
                assign amt_in = tail_amt;
            end
            else
            begin : g_mid
                assign key_in = key_q[i+1];
                assign amt_in = amt_q[i+1];
            end
            kqt_cell #(
                .KW (KW),
                .QW (QW)
            ) u_cell (
                .clk    (clk),
                .rotate (rotate),
                .key_in (key_in),
                .amt_in (amt_in),
                .key    (key_q[i]),
                .amt    (amt_q[i])
            );
        end
    endgenerate

    assign req_stall = stat.busy;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        stat.count <= POS_BITS'(DEPTH))
        else $error("entry count above table depth");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall && (req.mode != MODE_NONE)) |=> req_stall)
        else $error("request accepted without starting a turn");

    a_single_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (rsp.status != ST_LISTED)) |-> (rsp.last && (rsp.position == '0)))
        else $error("single result without last or with a position");

    a_listed_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (rsp.status == ST_LISTED)) |->
            ((rsp.position != '0) && (rsp.position <= POS_BITS'(stat.count))))
        else $error("listed position outside the table");

endmodule

`default_nettype wire

// File: rtl/kqt_cell.sv
// One table cell: a key and a quantity that move to the next cell on each rotate.
`default_nettype none

module kqt_cell #(
    parameter int KW = 16,
    parameter int QW = 32
) (
    input  wire logic          clk,
    input  wire logic          rotate,
    input  wire logic [KW-1:0] key_in,
    input  wire logic [QW-1:0] amt_in,
    output logic      [KW-1:0] key,
    output logic      [QW-1:0] amt
);

    logic [KW-1:0] key_reg;
    logic [QW-1:0] amt_reg;

    always_ff @(posedge clk)
    begin
        if (rotate)
        begin
            key_reg <= key_in;
            amt_reg <= amt_in;
        end
    end

    assign key = key_reg;
    assign amt = amt_reg;

endmodule

`default_nettype wire

// File: rtl/kqt_ctrl.sv
// Sequencer: steps the cell ring once per list, store or offstore request and edits entries at the head cell.
`default_nettype none

module kqt_ctrl import kqt_pkg::*; #(
    parameter int DEPTH = 16,
    parameter int KW    = 16,
    parameter int QW    = 32
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    input  wire req_t          req,
    input  wire logic          rsp_stall,
    output logic               rsp_valid,
    output rsp_t               rsp,
    output kqt_stat_t          stat,
    input  wire logic [KW-1:0] head_key,
    input  wire logic [QW-1:0] head_amt,
    input  wire logic [KW-1:0] next_key,
    input  wire logic [QW-1:0] next_amt,
    output logic               rotate,
    output logic      [KW-1:0] tail_key,
    output logic      [QW-1:0] tail_amt
);

    localparam int SW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [SW-1:0] STEP_LAST = SW'(DEPTH - 1);

    logic          busy_reg, busy_next;
    logic [SW-1:0] step_reg, step_next;
    logic [CW-1:0] count_reg, count_next;
    logic          hit_reg, hit_next;
    logic          close_reg, close_next;
    logic          grow_reg, grow_next;
    logic          shrink_reg, shrink_next;
    logic [1:0]    mode_reg;
    logic [KW-1:0] key_reg;
    logic [QW-1:0] qty_reg;
    logic [2:0]    res_status_reg;
    logic [QW-1:0] res_qty_reg;
    logic          rsp_valid_reg, rsp_valid_next;
    rsp_t          rsp_reg;

    logic          accept;
    logic          out_free;
    logic          is_list, is_store, is_off;
    logic [CW-1:0] step_w;
    logic          in_range, final_step, match;
    logic [QW:0]   sum;
    logic [QW-1:0] sat, diff;
    logic          take_all;
    logic          ev;
    logic [2:0]    ev_status;
    logic [QW-1:0] ev_qty;
    logic          grow_now, shrink_now, close_now;
    logic          emit, advance;
    rsp_t          rsp_now;
    logic [2:0]    fin_status;
    logic [QW-1:0] fin_qty;

    assign accept   = req_valid && !busy_reg;
    assign out_free = !rsp_valid_reg || !rsp_stall;
    assign is_list  = (mode_reg == MODE_LIST);
    assign is_store = (mode_reg == MODE_STORE);
    assign is_off   = (mode_reg == MODE_OFF);

    // At step s the head cell holds the entry that started at position s.
    assign step_w     = CW'(step_reg);
    assign in_range   = step_w < count_reg;
    assign final_step = (step_reg == STEP_LAST);
    assign match      = !is_list && in_range && (head_key == key_reg) && !hit_reg;

    assign sum      = {1'b0, head_amt} + {1'b0, qty_reg};
    assign sat      = sum[QW] ? {QW{1'b1}} : sum[QW-1:0];
    assign take_all = (qty_reg >= head_amt);
    assign diff     = head_amt - qty_reg;

    always_comb
    begin
        tail_key   = head_key;
        tail_amt   = head_amt;
        ev         = 1'b0;
        ev_status  = ST_ADDED;
        ev_qty     = '0;
        grow_now   = 1'b0;
        shrink_now = 1'b0;
        close_now  = 1'b0;
        // Once an entry is dropped, every later entry enters the tail from one
        // cell further on, which closes the gap after the full turn.
        if (close_reg)
        begin
            tail_key = next_key;
            tail_amt = next_amt;
        end
        if (match && is_store)
        begin
            tail_amt  = sat;
            ev        = 1'b1;
            ev_status = ST_ADDED;
            ev_qty    = sat;
        end
        if (match && is_off)
        begin
            ev = 1'b1;
            if (!take_all)
            begin
                tail_amt  = diff;
                ev_status = ST_REDUCED;
                ev_qty    = diff;
            end
            else
            begin
                tail_key   = next_key;
                tail_amt   = next_amt;
                ev_status  = ST_REMOVED;
                ev_qty     = '0;
                shrink_now = 1'b1;
                close_now  = 1'b1;
            end
        end
        // The first free slot passes the head right after the last valid entry.
        if (is_store && !hit_reg && (step_w == count_reg))
        begin
            tail_key  = key_reg;
            tail_amt  = qty_reg;
            ev        = 1'b1;
            ev_status = ST_NEW;
            ev_qty    = qty_reg;
            grow_now  = 1'b1;
        end
    end

    always_comb
    begin
        if (ev)
        begin
            fin_status = ev_status;
            fin_qty    = ev_qty;
        end
        else if (hit_reg)
        begin
            fin_status = res_status_reg;
            fin_qty    = res_qty_reg;
        end
        else
        begin
            fin_status = is_store ? ST_FULL : ST_NOTFOUND;
            fin_qty    = '0;
        end
    end

    always_comb
    begin
        rsp_now = '0;
        if (is_list)
        begin
            if (in_range)
            begin
                rsp_now.status         = ST_LISTED;
                rsp_now.position       = POS_BITS'(step_reg) + POS_BITS'(1);
                rsp_now.entry_type     = FIELD_KEY_BITS'(head_key);
                rsp_now.entry_quantity = FIELD_QTY_BITS'(head_amt);
                rsp_now.last           = (CW'(step_w + CW'(1)) == count_reg);
            end
            else
            begin
                rsp_now.status = ST_EMPTY;
                rsp_now.last   = 1'b1;
            end
        end
        else
        begin
            rsp_now.status         = fin_status;
            rsp_now.entry_type     = FIELD_KEY_BITS'(key_reg);
            rsp_now.entry_quantity = FIELD_QTY_BITS'(fin_qty);
            rsp_now.last           = 1'b1;
        end
    end

    assign emit    = is_list ? (in_range || (final_step && (count_reg == '0))) : final_step;
    assign advance = busy_reg && (!emit || out_free);
    assign rotate  = advance;

    always_comb
    begin
        busy_next   = busy_reg;
        step_next   = step_reg;
        count_next  = count_reg;
        hit_next    = hit_reg;
        close_next  = close_reg;
        grow_next   = grow_reg;
        shrink_next = shrink_reg;
        if (accept && (req.mode != MODE_NONE))
        begin
            busy_next   = 1'b1;
            step_next   = '0;
            hit_next    = 1'b0;
            close_next  = 1'b0;
            grow_next   = 1'b0;
            shrink_next = 1'b0;
        end
        if (advance)
        begin
            step_next   = SW'(step_reg + SW'(1));
            hit_next    = hit_reg | ev;
            close_next  = close_reg | close_now;
            grow_next   = grow_reg | grow_now;
            shrink_next = shrink_reg | shrink_now;
            if (final_step)
            begin
                busy_next  = 1'b0;
                count_next = CW'(count_reg + CW'(grow_reg | grow_now)
                                 - CW'(shrink_reg | shrink_now));
            end
        end
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (advance && emit)
            rsp_valid_next = 1'b1;
        else if (rsp_valid_reg && !rsp_stall)
            rsp_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            step_reg      <= '0;
            count_reg     <= '0;
            hit_reg       <= 1'b0;
            close_reg     <= 1'b0;
            grow_reg      <= 1'b0;
            shrink_reg    <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            step_reg      <= step_next;
            count_reg     <= count_next;
            hit_reg       <= hit_next;
            close_reg     <= close_next;
            grow_reg      <= grow_next;
            shrink_reg    <= shrink_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg <= req.mode;
            key_reg  <= req.goods_type[KW-1:0];
            qty_reg  <= req.quantity[QW-1:0];
        end
        if (advance && ev)
        begin
            res_status_reg <= ev_status;
            res_qty_reg    <= ev_qty;
        end
        if (advance && emit)
            rsp_reg <= rsp_now;
    end

    assign rsp_valid  = rsp_valid_reg;
    assign rsp        = rsp_reg;
    assign stat.busy  = busy_reg;
    assign stat.count = POS_BITS'(count_reg);

endmodule

`default_nettype wire
